@@ hdl/tdfir_pkg.sv @@
package tdfir_pkg;

    // Sizes of the block
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int ACCEL_TAPS  = 21;
    localparam int RATE_TAPS   = 11;
    localparam int AXES        = 3;
    localparam int AXIS_SLOTS  = 3;
    localparam int COEF_MAX    = 64;
    localparam int FRAC_BITS   = 15;

    // Accumulator: full product plus headroom for up to COEF_MAX terms
    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W     = PROD_BITS + $clog2(COEF_MAX) + 1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

    // Filter kind codes
    typedef enum logic
    {
        KIND_ACCEL = 1'b0,
        KIND_RATE  = 1'b1
    } kind_t;

    // Per-request control handed to each lane
    typedef struct packed
    {
        logic  accel_en;
        logic  rate_en;
        kind_t kind;
    } lane_ctl_t;

    // Q1.15 coefficient tables
    localparam coef_t ACCEL_COEF [21] = '{
        -16'sd618, -16'sd36, 16'sd100, 16'sd488, 16'sd999, 16'sd1608, 16'sd2306,
        16'sd2948, 16'sd3435, 16'sd3764, 16'sd3889, 16'sd3764, 16'sd3435,
        16'sd2948, 16'sd2306, 16'sd1608, 16'sd999, 16'sd488, 16'sd100,
        -16'sd36, -16'sd618
    };

    localparam coef_t RATE_COEF [11] = '{
        16'sd1007, 16'sd1587, 16'sd2747, 16'sd3646, 16'sd4399, 16'sd4592,
        16'sd4399, 16'sd3646, 16'sd2747, 16'sd1587, 16'sd1007
    };

    // Taps past the end of a table weigh nothing
    function automatic coef_t accel_coef(input int k);
        coef_t c;
        c = '0;
        if (k < 21)
        begin
            c = ACCEL_COEF[k];
        end
        return c;
    endfunction

    function automatic coef_t rate_coef(input int k);
        coef_t c;
        c = '0;
        if (k < 11)
        begin
            c = RATE_COEF[k];
        end
        return c;
    endfunction

    localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_BITS - 1);
    localparam acc_t SAT_HI     = acc_t'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam acc_t SAT_LO     = -SAT_HI - acc_t'(1);

    // Round half up, drop the fraction, clamp to the sample range
    function automatic sample_t finish(input acc_t acc);
        acc_t    r;
        sample_t y;
        r = (acc + ROUND_HALF) >>> FRAC_BITS;
        if (r > SAT_HI)
        begin
            y = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (r < SAT_LO)
        begin
            y = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            y = r[SAMPLE_BITS-1:0];
        end
        return y;
    endfunction

endpackage

@@ hdl/three_axis_dual_fir_filter_top.sv @@
// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------------------
// input    | in_valid / in_ready   | kind, sample_x, sample_y, sample_z
// output   | out_valid / out_ready | kind_out, filtered_x, filtered_y, filtered_z
//
// One request per cycle while the output is not stalled; each result is held
// in the sum stage and then in the output stage. Each axis runs a
// transposed-form chain of cells per bank, so the sum for a request is ready in
// the cycle it is taken; one register stage holds the sum, the next rounds,
// saturates and presents it. Reset clears every partial sum (empty delay lines)
// and the valid flags of both stages at once. A stalled output holds the result;
// two requests are buffered before in_ready drops.
module three_axis_dual_fir_filter_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  tdfir_pkg::sample_t  sample_x,
    input  tdfir_pkg::sample_t  sample_y,
    input  tdfir_pkg::sample_t  sample_z,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                kind_out,
    output tdfir_pkg::sample_t  filtered_x,
    output tdfir_pkg::sample_t  filtered_y,
    output tdfir_pkg::sample_t  filtered_z
);
    import tdfir_pkg::*;

    logic      take;
    logic      move_b;
    logic      move_a;
    lane_ctl_t ctl;
    sample_t   smp     [AXIS_SLOTS];
    acc_t      lane_acc[AXIS_SLOTS];

    logic      a_valid_reg;
    logic      a_valid_next;
    logic      a_kind_reg;
    acc_t      a_acc_reg [AXIS_SLOTS];
    logic      b_valid_reg;
    logic      b_valid_next;
    logic      b_kind_reg;
    sample_t   b_res_reg [AXIS_SLOTS];

    // Handshake and stage advance
    assign move_b   = !b_valid_reg || out_ready;
    assign move_a   = !a_valid_reg || move_b;
    assign in_ready = move_a;
    assign take     = in_valid && in_ready;

    assign ctl.kind     = kind_t'(kind);
    assign ctl.accel_en = take && (kind_t'(kind) == KIND_ACCEL);
    assign ctl.rate_en  = take && (kind_t'(kind) == KIND_RATE);

    assign smp[0] = sample_x;
    assign smp[1] = sample_y;
    assign smp[2] = sample_z;

    // One lane per axis in use
    for (genvar a = 0; a < AXIS_SLOTS; a++)
    begin : g_axis
        if (a < AXES)
        begin : g_used
            tdfir_lane u_lane
            (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (ctl),
                .sample (smp[a]),
                .acc    (lane_acc[a])
            );
        end
        else
        begin : g_unused
            assign lane_acc[a] = '0;
        end
    end

    assign a_valid_next = take ? 1'b1 : (move_b ? 1'b0 : a_valid_reg);
    assign b_valid_next = move_b ? a_valid_reg : b_valid_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Sum stage and output stage
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_kind_reg <= kind;
            a_acc_reg  <= lane_acc;
        end
        if (move_b && a_valid_reg)
        begin
            b_kind_reg <= a_kind_reg;
            for (int a = 0; a < AXIS_SLOTS; a++)
            begin
                b_res_reg[a] <= finish(a_acc_reg[a]);
            end
        end
    end

    assign out_valid  = b_valid_reg;
    assign kind_out   = b_kind_reg;
    assign filtered_x = b_res_reg[0];
    assign filtered_y = b_res_reg[1];
    assign filtered_z = b_res_reg[2];

    // Checks
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && b_valid_reg && !out_ready) |-> !in_ready)
        else $error("request taken while both stages are held");

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> a_valid_reg)
        else $error("accepted request did not reach the sum stage");

    a_kind_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && move_b) |=> (out_valid && kind_out == $past(a_kind_reg)))
        else $error("kind lost between sum and output stages");

    a_one_bank: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.accel_en && ctl.rate_en))
        else $error("both banks advanced by one request");

endmodule

@@ hdl/tdfir_cell.sv @@
module tdfir_cell
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  tdfir_pkg::sample_t sample,
    input  tdfir_pkg::coef_t   coef,
    input  tdfir_pkg::acc_t    sum_in,
    output tdfir_pkg::acc_t    sum_out
);
    import tdfir_pkg::*;

    prod_t prod;
    acc_t  sum_reg;
    acc_t  sum_next;

    // Partial sum of the transposed form: own tap plus the neighbour's sum
    assign prod     = prod_t'(coef) * prod_t'(sample);
    assign sum_next = en ? (acc_t'(prod) + sum_in) : sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum_out = sum_reg;

endmodule

@@ hdl/tdfir_lane.sv @@
module tdfir_lane
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tdfir_pkg::lane_ctl_t  ctl,
    input  tdfir_pkg::sample_t    sample,
    output tdfir_pkg::acc_t       acc
);
    import tdfir_pkg::*;

    // Index k holds the partial sum from tap k onwards; the last is empty
    acc_t accel_sum [ACCEL_TAPS+1];
    acc_t rate_sum  [RATE_TAPS+1];
    prod_t accel_prod0;
    prod_t rate_prod0;

    assign accel_sum[ACCEL_TAPS] = '0;
    assign rate_sum[RATE_TAPS]   = '0;

    // Acceleration chain
    for (genvar k = 1; k < ACCEL_TAPS; k++)
    begin : g_accel
        tdfir_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (ctl.accel_en),
            .sample  (sample),
            .coef    (accel_coef(k)),
            .sum_in  (accel_sum[k+1]),
            .sum_out (accel_sum[k])
        );
    end

    // Angular rate chain
    for (genvar k = 1; k < RATE_TAPS; k++)
    begin : g_rate
        tdfir_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (ctl.rate_en),
            .sample  (sample),
            .coef    (rate_coef(k)),
            .sum_in  (rate_sum[k+1]),
            .sum_out (rate_sum[k])
        );
    end

    // Head tap closes the sum for the new sample
    assign accel_prod0  = prod_t'(accel_coef(0)) * prod_t'(sample);
    assign rate_prod0   = prod_t'(rate_coef(0)) * prod_t'(sample);
    assign accel_sum[0] = acc_t'(accel_prod0) + accel_sum[1];
    assign rate_sum[0]  = acc_t'(rate_prod0) + rate_sum[1];

    assign acc = (ctl.kind == KIND_RATE) ? rate_sum[0] : accel_sum[0];

endmodule

@@ verif/tb_three_axis_dual_fir_filter_top.sv @@
`timescale 1ns / 100ps

module tb_three_axis_dual_fir_filter_top;

    import tdfir_pkg::sample_t;
    import tdfir_pkg::kind_t;
    import tdfir_pkg::KIND_ACCEL;
    import tdfir_pkg::KIND_RATE;

    localparam int ACCEL_LEN      = 21;
    localparam int RATE_LEN       = 11;
    localparam int AXIS_COUNT     = 3;
    localparam int RANDOM_ITEMS   = 524;
    localparam int QUIET_TAIL     = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int REPORT_LIMIT   = 10;

    localparam sample_t SAMPLE_MAX = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    // Q1.15 taps of the two banks
    localparam int ACCEL_WEIGHT [ACCEL_LEN] = '{
        -618, -36, 100, 488, 999, 1608, 2306, 2948, 3435, 3764, 3889,
        3764, 3435, 2948, 2306, 1608, 999, 488, 100, -36, -618
    };
    localparam int RATE_WEIGHT [RATE_LEN] = '{
        1007, 1587, 2747, 3646, 4399, 4592, 4399, 3646, 2747, 1587, 1007
    };

    typedef struct packed
    {
        kind_t   kind;
        sample_t x;
        sample_t y;
        sample_t z;
    } filt_result_t;

    typedef struct packed
    {
        kind_t        kind;
        sample_t      x;
        sample_t      y;
        sample_t      z;
        logic         known_result;
        filt_result_t result;
    } stim_row_t;

    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    in_valid   = 1'b0;
    logic    in_ready;
    logic    kind       = 1'b0;
    sample_t sample_x   = '0;
    sample_t sample_y   = '0;
    sample_t sample_z   = '0;
    logic    out_valid;
    logic    out_ready  = 1'b0;
    logic    kind_out;
    sample_t filtered_x;
    sample_t filtered_y;
    sample_t filtered_z;

    // Filter delay lines of the predictor, empty after reset
    sample_t accel_line [AXIS_COUNT][ACCEL_LEN] = '{default: '0};
    sample_t rate_line  [AXIS_COUNT][RATE_LEN]  = '{default: '0};

    filt_result_t pending_results [$];
    stim_row_t    directed_rows [$];

    int   fail_count    = 0;
    int   idle_pct      = 20;
    logic drain_quietly = 1'b0;
    int   ready_pct     = 0;
    int   ready_hold    = 0;
    int   ready_epoch   = 0;
    int   stall_cycles  = 0;

    three_axis_dual_fir_filter_top u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .sample_x   (sample_x),
        .sample_y   (sample_y),
        .sample_z   (sample_z),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind_out   (kind_out),
        .filtered_x (filtered_x),
        .filtered_y (filtered_y),
        .filtered_z (filtered_z)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Round half up, drop 15 fraction bits, clamp to 16 bits
    function automatic sample_t round_saturate(input longint acc);
        longint r;
        r = (acc + 64'sd16384) >>> 15;
        if (r > longint'(SAMPLE_MAX))
        begin
            r = longint'(SAMPLE_MAX);
        end
        else if (r < longint'(SAMPLE_MIN))
        begin
            r = longint'(SAMPLE_MIN);
        end
        return sample_t'(r);
    endfunction

    // Shift one triple into the selected bank and sum each axis
    function automatic filt_result_t filter_step(input kind_t k, input sample_t sx,
                                                 input sample_t sy, input sample_t sz);
        sample_t      axis_in  [AXIS_COUNT];
        sample_t      axis_out [AXIS_COUNT];
        longint       acc;
        int           a;
        int           t;
        filt_result_t res;
        axis_in[0] = sx;
        axis_in[1] = sy;
        axis_in[2] = sz;
        for (a = 0; a < AXIS_COUNT; a++)
        begin
            acc = 0;
            if (k == KIND_ACCEL)
            begin
                for (t = ACCEL_LEN - 1; t > 0; t--)
                begin
                    accel_line[a][t] = accel_line[a][t-1];
                end
                accel_line[a][0] = axis_in[a];
                for (t = 0; t < ACCEL_LEN; t++)
                begin
                    acc += longint'(ACCEL_WEIGHT[t]) * longint'(accel_line[a][t]);
                end
            end
            else
            begin
                for (t = RATE_LEN - 1; t > 0; t--)
                begin
                    rate_line[a][t] = rate_line[a][t-1];
                end
                rate_line[a][0] = axis_in[a];
                for (t = 0; t < RATE_LEN; t++)
                begin
                    acc += longint'(RATE_WEIGHT[t]) * longint'(rate_line[a][t]);
                end
            end
            axis_out[a] = round_saturate(acc);
        end
        res.kind = k;
        res.x    = axis_out[0];
        res.y    = axis_out[1];
        res.z    = axis_out[2];
        return res;
    endfunction

    function automatic sample_t pick_extreme();
        sample_t v;
        case ($urandom_range(0, 4))
            0: v = SAMPLE_MIN;
            1: v = SAMPLE_MAX;
            2: v = '0;
            3: v = -16'sd1;
            default: v = 16'sd1;
        endcase
        return v;
    endfunction

    task automatic note_failure(input string what, input filt_result_t want,
                                input filt_result_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s: expected kind %0d x %0d y %0d z %0d, got kind %0d x %0d y %0d z %0d",
                     $time, what, want.kind, $signed(want.x), $signed(want.y),
                     $signed(want.z), got.kind, $signed(got.x), $signed(got.y),
                     $signed(got.z));
        end
    endtask

    task automatic add_row(input kind_t k, input int x, input int y, input int z,
                           input logic known, input int ex, input int ey, input int ez);
        stim_row_t row;
        row.kind          = k;
        row.x             = sample_t'(x);
        row.y             = sample_t'(y);
        row.z             = sample_t'(z);
        row.known_result  = known;
        row.result.kind   = k;
        row.result.x      = sample_t'(ex);
        row.result.y      = sample_t'(ey);
        row.result.z      = sample_t'(ez);
        directed_rows.push_back(row);
    endtask

    // Present one request, hold it until taken, then log what must come back
    task automatic issue_sample(input kind_t k, input sample_t sx, input sample_t sy,
                                input sample_t sz, input logic use_given,
                                input filt_result_t given);
        int           gap;
        filt_result_t predicted;
        gap = 0;
        if (!drain_quietly && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 14);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        sample_x <= sx;
        sample_y <= sy;
        sample_z <= sz;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predicted = filter_step(k, sx, sy, sz);
        pending_results.push_back(use_given ? given : predicted);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Stimulus
    initial
    begin : stimulus
        int      sent;
        int      seg_len;
        int      seg_mode;
        int      i;
        int      a;
        int      r;
        logic    kind_mixed;
        logic    mid_pause_done;
        kind_t   seg_kind;
        kind_t   k;
        sample_t seg_const [AXIS_COUNT];
        sample_t samp [AXIS_COUNT];

        // Empty lines give zero; first rate tap alone passes +-1007
        add_row(KIND_ACCEL, 0, 0, 0, 1'b1, 0, 0, 0);
        add_row(KIND_RATE, 0, 0, 0, 1'b1, 0, 0, 0);
        add_row(KIND_RATE, 32767, -32768, 1, 1'b1, 1007, -1007, 0);
        // Full-scale acceleration run with one rate request in the middle;
        // the rate bank must not disturb the acceleration lines
        for (r = 0; r < ACCEL_LEN; r++)
        begin
            if (r == 10)
            begin
                add_row(KIND_RATE, -1, 1, -32768, 1'b0, 0, 0, 0);
            end
            if (r == ACCEL_LEN - 1)
            begin
                add_row(KIND_ACCEL, 32767, -32768, 32767, 1'b1, 32767, -32768, 32767);
            end
            else
            begin
                add_row(KIND_ACCEL, 32767, -32768, 32767, 1'b0, 0, 0, 0);
            end
        end
        add_row(KIND_RATE, 12345, -23456, -1, 1'b0, 0, 0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            issue_sample(directed_rows[r].kind, directed_rows[r].x, directed_rows[r].y,
                         directed_rows[r].z, directed_rows[r].known_result,
                         directed_rows[r].result);
        end
        hold_until_drained();

        // Random segments: each has its own value pattern, kind mix and idle rate
        sent           = 0;
        mid_pause_done = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            seg_len    = $urandom_range(1, 32);
            seg_mode   = $urandom_range(0, 4);
            kind_mixed = ($urandom_range(0, 2) == 0);
            seg_kind   = kind_t'($urandom_range(0, 1));
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 35;
            endcase
            for (a = 0; a < AXIS_COUNT; a++)
            begin
                seg_const[a] = pick_extreme();
            end
            for (i = 0; i < seg_len; i++)
            begin
                if (sent >= RANDOM_ITEMS)
                begin
                    break;
                end
                if (RANDOM_ITEMS - sent <= QUIET_TAIL)
                begin
                    drain_quietly = 1'b1;
                end
                if (!mid_pause_done && sent >= RANDOM_ITEMS / 2)
                begin
                    hold_until_drained();
                    mid_pause_done = 1'b1;
                end
                k = kind_mixed ? kind_t'($urandom_range(0, 1)) : seg_kind;
                for (a = 0; a < AXIS_COUNT; a++)
                begin
                    case (seg_mode)
                        0: samp[a] = sample_t'($urandom);
                        1: samp[a] = seg_const[a];
                        2: samp[a] = ((i + a) % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
                        3: samp[a] = sample_t'(int'($urandom_range(0, 400)) - 200);
                        default: samp[a] = pick_extreme();
                    endcase
                end
                issue_sample(k, samp[0], samp[1], samp[2], 1'b0, '0);
                sent++;
            end
        end

        // Wind down: let every result arrive and settle before the verdict
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb_three_axis_dual_fir_filter_top passed");
        end
        else
        begin
            $display("tb_three_axis_dual_fir_filter_top failed");
        end
        $finish;
    end

    // Result side back-pressure in bursts; stall rate is redrawn at each new ready epoch
    always @(posedge clk)
    begin
        ready_epoch <= ready_epoch + 1;
        if (ready_epoch % 64 == 0)
        begin
            case ($urandom_range(0, 2))
                0: ready_pct <= 0;
                1: ready_pct <= 15;
                default: ready_pct <= 45;
            endcase
        end
        if (ready_hold > 0 && !drain_quietly)
        begin
            out_ready  <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else if (rst_n && !drain_quietly && $urandom_range(0, 99) < ready_pct)
        begin
            out_ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 13);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Compare each result with the oldest outstanding request
    always @(posedge clk)
    begin : check_results
        filt_result_t got;
        filt_result_t want;
        got.kind = kind_t'(kind_out);
        got.x    = filtered_x;
        got.y    = filtered_y;
        got.z    = filtered_z;
        if (rst_n && $isunknown(out_valid))
        begin
            note_failure("out_valid unknown", '0, got);
        end
        else if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                note_failure("result with no request pending", '0, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (kind_out !== want.kind || filtered_x !== want.x ||
                    filtered_y !== want.y || filtered_z !== want.z)
                begin
                    note_failure("result mismatch", want, got);
                end
            end
        end
    end

    // Watchdog: too long without any request or result moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_three_axis_dual_fir_filter_top failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
